// File: hw/rtl/idct4x4_add_clip_assert.svh
// Assertion macros for the checker file of the inverse transform block.
`ifndef IDCT4X4_ADD_CLIP_ASSERT_SVH
`define IDCT4X4_ADD_CLIP_ASSERT_SVH

// Checked on every rising edge while reset is released.
`define IDCT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define IDCT_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/idct_pkg.sv
`timescale 1ns / 1ps
package idct_pkg;

  localparam int COEF_W = 16;
  localparam int PIX_W = 8;
  // Value widths after the vertical and the horizontal pass.
  localparam int T_W = COEF_W + 2;
  localparam int H_W = T_W + 2;

  localparam int K_W = 16;
  localparam int K_SHIFT = 16;
  localparam logic signed [K_W:0] K_COS_S = 17'sd20091;
  localparam logic signed [K_W:0] K_SIN_S = 17'sd35468;

  localparam int ROUND_BIAS = 4;
  localparam int ROUND_SHIFT = 3;
  localparam int PIX_MAX = 255;

  localparam int ROW_W = 2;
  localparam logic [ROW_W-1:0] LAST_ROW = 2'd3;

  localparam int CNT_W = 3;
  localparam logic [CNT_W-1:0] CALC_LAT = 3'd4;

  typedef struct packed {
    logic             load;
    logic [ROW_W-1:0] row;
  } merge_ctrl_t;

endpackage

// File: hw/rtl/idct4x4_add_clip.sv
`timescale 1ns / 1ps
// 4x4 inverse transform with prediction add and clip, as used for VP8 residual
// reconstruction. A block enters one row per word, four signed coefficients and
// four prediction pixels, and the rows are written into a small register store.
// After the fourth row the input stalls while four transform lanes work down the
// columns in parallel and four more work along the rows; each lane is a two-stage
// pipeline, and the sequencer waits for the horizontal results in its calc state.
// The merge stage then rounds, adds the prediction, clips and presents row 0;
// rows 1 to 3 follow one per cycle as the downstream side takes them.
// The spacing between blocks is set by the drain of the four output words and the
// two lane pipelines: the input stays stalled from the fourth row until the last
// output word is taken.
module idct4x4_add_clip import idct_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [COEF_W-1:0] coef_a_i,
  input  logic signed [COEF_W-1:0] coef_b_i,
  input  logic signed [COEF_W-1:0] coef_c_i,
  input  logic signed [COEF_W-1:0] coef_d_i,
  input  logic        [PIX_W-1:0]  pred_a_i,
  input  logic        [PIX_W-1:0]  pred_b_i,
  input  logic        [PIX_W-1:0]  pred_c_i,
  input  logic        [PIX_W-1:0]  pred_d_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic        [PIX_W-1:0]  pix_a_o,
  output logic        [PIX_W-1:0]  pix_b_o,
  output logic        [PIX_W-1:0]  pix_c_o,
  output logic        [PIX_W-1:0]  pix_d_o,
  output logic        [ROW_W-1:0]  row_index_o,
  output logic                     last_row_o
);

  typedef enum logic [2:0] {
    ST_FILL = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [ROW_W-1:0]  rows_q, rows_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              valid_q, valid_d;
  logic              in_acc, out_acc;
  merge_ctrl_t       mctl;

  // Block store, row-major.
  logic signed [COEF_W-1:0] coef_q [4][4];
  logic        [PIX_W-1:0]  pred_q [4][4];

  // Lane wiring: vertical lanes take columns, horizontal lanes take rows.
  logic signed [COEF_W-1:0] vcol [4][4];
  logic signed [T_W-1:0]    vout [4][4];
  logic signed [T_W-1:0]    hin  [4][4];
  logic signed [H_W-1:0]    hout [4][4];
  logic        [PIX_W-1:0]  pix  [4];

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      coef_q[rows_q] <= '{coef_a_i, coef_b_i, coef_c_i, coef_d_i};
      pred_q[rows_q] <= '{pred_a_i, pred_b_i, pred_c_i, pred_d_i};
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        vcol[c][r] = coef_q[r][c];
        hin[r][c]  = vout[c][r];
      end
    end
  end

  // The lanes run every cycle; the store holds still while a block is in
  // flight, so their outputs settle and stay put until the block is emitted.
  for (genvar g = 0; g < 4; g++) begin : g_lane
    idct_lane #(
      .IW(COEF_W)
    ) u_vert (
      .clk_i(clk_i),
      .v_i  (vcol[g]),
      .o_o  (vout[g])
    );

    idct_lane #(
      .IW(T_W)
    ) u_horz (
      .clk_i(clk_i),
      .v_i  (hin[g]),
      .o_o  (hout[g])
    );
  end

  idct_merge u_merge (
    .clk_i (clk_i),
    .ctl_i (mctl),
    .h_i   (hout),
    .pred_i(pred_q),
    .pix_o (pix),
    .row_o (row_index_o),
    .last_o(last_row_o)
  );

  // Sequencer: fill four rows, wait out the lane pipelines, then emit four rows.
  always_comb begin
    state_d   = state_q;
    rows_d    = rows_q;
    cnt_d     = cnt_q;
    valid_d   = valid_q;
    mctl.load = 1'b0;
    mctl.row  = row_index_o;
    case (state_q)
      ST_FILL: begin
        if (in_acc) begin
          rows_d = rows_q + 2'd1;
          if (rows_q == LAST_ROW) begin
            state_d = ST_CALC;
            cnt_d   = '0;
          end
        end
      end
      ST_CALC: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == CALC_LAT) begin
          state_d   = ST_EMIT;
          valid_d   = 1'b1;
          mctl.load = 1'b1;
          mctl.row  = '0;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (last_row_o) begin
            valid_d = 1'b0;
            state_d = ST_FILL;
          end else begin
            mctl.load = 1'b1;
            mctl.row  = row_index_o + 2'd1;
          end
        end
      end
      default: begin
        state_d = ST_FILL;
        valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      rows_q  <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rows_q  <= rows_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_FILL);
  assign out_valid_o = valid_q;
  assign pix_a_o     = pix[0];
  assign pix_b_o     = pix[1];
  assign pix_c_o     = pix[2];
  assign pix_d_o     = pix[3];

endmodule

// File: hw/rtl/idct_lane.sv
`timescale 1ns / 1ps
module idct_lane import idct_pkg::*; #(
  parameter int IW = 16
) (
  input  logic                 clk_i,
  input  logic signed [IW-1:0] v_i [4],
  output logic signed [IW+1:0] o_o [4]
);

  localparam int MW = IW + 1;
  localparam int OW = IW + 2;
  localparam int PW = IW + K_W + 1;

  logic signed [PW-1:0] p_sin1, p_cos1, p_sin3, p_cos3;
  logic signed [MW-1:0] a_q, b_q, sin1_q, cos1_q, sin3_q, cos3_q;
  logic signed [IW-1:0] v1_q, v3_q;
  logic signed [OW-1:0] c_d, d_d;
  logic signed [OW-1:0] o_q [4];

  assign p_sin1 = v_i[1] * K_SIN_S;
  assign p_cos1 = v_i[1] * K_COS_S;
  assign p_sin3 = v_i[3] * K_SIN_S;
  assign p_cos3 = v_i[3] * K_COS_S;

  // First stage: products with the shift applied, and the even half.
  always_ff @(posedge clk_i) begin
    a_q    <= MW'(v_i[0]) + MW'(v_i[2]);
    b_q    <= MW'(v_i[0]) - MW'(v_i[2]);
    sin1_q <= p_sin1[PW-1:K_SHIFT];
    cos1_q <= p_cos1[PW-1:K_SHIFT];
    sin3_q <= p_sin3[PW-1:K_SHIFT];
    cos3_q <= p_cos3[PW-1:K_SHIFT];
    v1_q   <= v_i[1];
    v3_q   <= v_i[3];
  end

  always_comb begin
    c_d = OW'(sin1_q) - (OW'(v3_q) + OW'(cos3_q));
    d_d = (OW'(v1_q) + OW'(cos1_q)) + OW'(sin3_q);
  end

  // Second stage: butterfly.
  always_ff @(posedge clk_i) begin
    o_q[0] <= OW'(a_q) + d_d;
    o_q[1] <= OW'(b_q) + c_d;
    o_q[2] <= OW'(b_q) - c_d;
    o_q[3] <= OW'(a_q) - d_d;
  end

  assign o_o = o_q;

endmodule

// File: hw/rtl/idct_merge.sv
`timescale 1ns / 1ps
module idct_merge import idct_pkg::*; (
  input  logic                    clk_i,
  input  merge_ctrl_t             ctl_i,
  input  logic signed [H_W-1:0]   h_i [4][4],
  input  logic        [PIX_W-1:0] pred_i [4][4],
  output logic        [PIX_W-1:0] pix_o [4],
  output logic        [ROW_W-1:0] row_o,
  output logic                    last_o
);

  localparam int RW = H_W + 1;

  logic signed [RW-1:0]    rnd [4];
  logic signed [RW-1:0]    sum [4];
  logic        [PIX_W-1:0] pix_d [4];
  logic        [PIX_W-1:0] pix_q [4];
  logic        [ROW_W-1:0] row_q;
  logic                    last_q;

  // Round, add the prediction and clip, for the row being loaded.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      rnd[j] = (RW'(h_i[ctl_i.row][j]) + RW'(ROUND_BIAS)) >>> ROUND_SHIFT;
      sum[j] = rnd[j] + RW'($signed({1'b0, pred_i[ctl_i.row][j]}));
      if (sum[j] < 0) begin
        pix_d[j] = '0;
      end else if (sum[j] > RW'(PIX_MAX)) begin
        pix_d[j] = PIX_W'(PIX_MAX);
      end else begin
        pix_d[j] = sum[j][PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      pix_q  <= pix_d;
      row_q  <= ctl_i.row;
      last_q <= (ctl_i.row == LAST_ROW);
    end
  end

  assign pix_o  = pix_q;
  assign row_o  = row_q;
  assign last_o = last_q;

endmodule

// File: hw/rtl/idct_chk.sv
`timescale 1ns / 1ps
`include "idct4x4_add_clip_assert.svh"
module idct_chk import idct_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic        [PIX_W-1:0] pix_a_o,
  input logic        [PIX_W-1:0] pix_b_o,
  input logic        [PIX_W-1:0] pix_c_o,
  input logic        [PIX_W-1:0] pix_d_o,
  input logic        [ROW_W-1:0] row_index_o,
  input logic                    last_row_o
);

  // A stalled output word holds its payload.
  `IDCT_ASSERT(a_out_hold,
    out_valid_o && out_stall_i |=>
      $stable({pix_a_o, pix_b_o, pix_c_o, pix_d_o, row_index_o, last_row_o}),
    "stalled output word changed")

  // No new row is taken while reconstructed rows are still being shown.
  `IDCT_ASSERT(a_no_fill_while_emit, out_valid_o |-> in_stall_o, "input open during emit")

  // After a non-final row is taken, the next row of the block follows at once.
  `IDCT_ASSERT(a_row_advance,
    out_valid_o && !out_stall_i && !last_row_o |=>
      out_valid_o && row_index_o == $past(row_index_o) + 2'd1,
    "output rows out of order")

  // The final row ends the block's output.
  `IDCT_ASSERT(a_block_end,
    out_valid_o && !out_stall_i && last_row_o |=> !out_valid_o,
    "output continued past final row")

  // Nothing is offered while reset is held.
  `IDCT_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

bind idct4x4_add_clip idct_chk u_idct_chk (.*);
